// File: design/bra_pkg.sv
package bra_pkg;

	localparam int INDEX_WIDTH = 24;
	localparam int ROW_LEN_W = 25;
	localparam int OUT_W = 25;
	localparam int LOGIT_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (INDEX_WIDTH + 1 > ROW_LEN_W) ? INDEX_WIDTH + 1 : ROW_LEN_W;

	localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = ROW_LEN_W'(1);
	localparam logic [7:0] EXP_NONFINITE = 8'hFF;

	typedef logic [INDEX_WIDTH-1:0] pos_t;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] key;
		logic nonfinite;
		pos_t pos;
		logic last;
	} bra_entry_t;

	// Monotonic signed key of a finite bfloat16; both zeros map to zero.
	function automatic logic signed [LOGIT_W-1:0] order_key(input logic [LOGIT_W-1:0] bits);
		logic signed [LOGIT_W-1:0] mag;
		mag = $signed({1'b0, bits[LOGIT_W-2:0]});
		return bits[LOGIT_W-1] ? -mag : mag;
	endfunction

endpackage

// File: design/bra_front.sv
module bra_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bra_pkg::ROW_LEN_W-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bra_pkg::LOGIT_W-1:0]       logit_bits,
	input  logic                              q_full,
	output logic                              q_push,
	output bra_pkg::bra_entry_t               q_entry
);
	import bra_pkg::*;

	logic [ROW_LEN_W-1:0] row_length_q;
	pos_t position_q;
	logic last;

	assign in_ready = !q_full;
	assign q_push = in_valid && in_ready;

	assign last = (CMP_W'(position_q) + CMP_W'(1) >= CMP_W'(row_length_q)) || (&position_q);

	always_comb begin
		q_entry.key = order_key(logit_bits);
		q_entry.nonfinite = (logit_bits[LOGIT_W-2 -: 8] == EXP_NONFINITE);
		q_entry.pos = position_q;
		q_entry.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LEN_RESET;
		end else if (cfg_wr_en) begin
			row_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (q_push) begin
			position_q <= last ? '0 : position_q + pos_t'(1);
		end
	end

endmodule

// File: design/bra_queue.sv
module bra_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bra_pkg::bra_entry_t    push_entry,
	output logic                   full,
	input  logic                   pop,
	output logic                   not_empty,
	output bra_pkg::bra_entry_t    head
);
	import bra_pkg::*;

	bra_entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("queue read while empty");

endmodule

// File: design/bra_back.sv
module bra_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_not_empty,
	input  bra_pkg::bra_entry_t             q_head,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bra_pkg::OUT_W-1:0]       best_index
);
	import bra_pkg::*;

	logic signed [LOGIT_W-1:0] best_key_q;
	pos_t best_pos_q;
	logic have_best_q;
	logic saw_nonfinite_q;
	logic out_valid_q;
	logic [OUT_W-1:0] best_index_q;

	logic take;
	logic saw_next;
	pos_t best_pos_next;

	assign q_pop = q_not_empty && (!q_head.last || !out_valid_q || out_ready);

	assign take = !q_head.nonfinite && (!have_best_q || (q_head.key > best_key_q));
	assign saw_next = saw_nonfinite_q || q_head.nonfinite;
	assign best_pos_next = take ? q_head.pos : best_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_key_q <= '0;
			best_pos_q <= '0;
			have_best_q <= 1'b0;
			saw_nonfinite_q <= 1'b0;
		end else if (q_pop) begin
			if (q_head.last) begin
				best_key_q <= '0;
				best_pos_q <= '0;
				have_best_q <= 1'b0;
				saw_nonfinite_q <= 1'b0;
			end else begin
				saw_nonfinite_q <= saw_next;
				if (take) begin
					best_key_q <= q_head.key;
					best_pos_q <= q_head.pos;
					have_best_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_head.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			best_index_q <= saw_next ? '1 : OUT_W'(best_pos_next);
		end
	end

	assign out_valid = out_valid_q;
	assign best_index = best_index_q;

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_head.last |=> !have_best_q && !saw_nonfinite_q)
		else $error("row state not cleared after last element");

	a_result_from_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(q_pop && q_head.last))
		else $error("result raised without a row end");

	a_no_best_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!have_best_q |-> (best_pos_q == '0))
		else $error("best position set without a best value");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(q_pop && q_head.last))
		else $error("result overwritten before it was taken");

endmodule

// File: design/bf16_row_argmax_core.sv
// Channel   Handshake               Payload
// logit     in_valid / in_ready     logit_bits[15:0], one bfloat16 logit of the row
// result    out_valid / out_ready   best_index[24:0], signed, -1 if the row held inf or NaN
// config    cfg_wr_en               cfg_wr_data[24:0], row_length, no wait, no read-back
//
// One logit request is accepted per cycle while the four-entry queue has room.
// The row's last logit is first written into the queue; the result is registered when that entry is popped.
// A stalled result holds the next row end at the queue head; in_ready drops once three
// more logits are queued behind it.
// arst_n clears the row state, the queue and the output valid; row_length resets to one.
module bf16_row_argmax_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bra_pkg::ROW_LEN_W-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bra_pkg::LOGIT_W-1:0]       logit_bits,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bra_pkg::OUT_W-1:0]         best_index
);
	import bra_pkg::*;

	bra_entry_t push_entry;
	bra_entry_t head;
	logic push;
	logic pop;
	logic full;
	logic not_empty;

	bra_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.logit_bits  (logit_bits),
		.q_full      (full),
		.q_push      (push),
		.q_entry     (push_entry)
	);

	bra_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	bra_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_head      (head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_index  (best_index)
	);

endmodule
